[hdl/dapid_pkg.sv]
package dapid_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int ANGLE_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int BAND_W   = 15;
    localparam int PULSE_W  = 11;
    localparam int ERR_W    = 16;
    localparam int ACC_W    = 24;
    localparam int SPEED_W  = 10;

    // Loop constants
    localparam logic [TIME_W-1:0]  MIN_PERIOD_MS = 32'd10;
    localparam int                 SPEED_LIMIT   = 500;
    localparam logic [PULSE_W-1:0] PULSE_STOP    = 11'd1500;
    localparam int                 ANGLE_HALF    = 23040;
    localparam int                 ANGLE_FULL    = 46080;
    localparam int                 ACC_LIMIT     = 6553600;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN_P    = 3'd0;
    localparam logic [2:0] REG_GAIN_I    = 3'd1;
    localparam logic [2:0] REG_GAIN_D    = 3'd2;
    localparam logic [2:0] REG_DEAD_BAND = 3'd3;
    localparam logic [2:0] REG_FLOOR     = 3'd4;
    localparam logic [2:0] REG_CEILING   = 3'd5;
    localparam logic [2:0] REG_ENABLE    = 3'd6;
    localparam logic [2:0] REG_SENSOR_OK = 3'd7;

    // Command from the sequencer to one channel
    typedef struct packed {
        logic start;
        logic run;
        logic clear;
    } chan_cmd_t;

endpackage

[hdl/dapid_if.sv]
interface dapid_in_if import dapid_pkg::*;;
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  now_ms;
    logic [ANGLE_W-1:0] left_angle;
    logic [ANGLE_W-1:0] right_angle;
    logic [ANGLE_W-1:0] left_target;
    logic [ANGLE_W-1:0] right_target;

    modport source (output valid, now_ms, left_angle, right_angle, left_target, right_target,
                    input ready);
    modport sink (input valid, now_ms, left_angle, right_angle, left_target, right_target,
                  output ready);
endinterface

interface dapid_out_if import dapid_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] left_pulse;
    logic [PULSE_W-1:0] right_pulse;
    logic               on_target;

    modport source (output valid, left_pulse, right_pulse, on_target, input ready);
    modport sink (input valid, left_pulse, right_pulse, on_target, output ready);
endinterface

[hdl/dual_angle_pid_servo_control_unit.sv]
// While a channel runs the loop, a tick's result waits on the bit-serial PID channel
// (multiply, divide and gain steps). A tick with both errors in the deadband or a
// disabled tick skips the channel steps, and an early tick of an enabled unit is dropped.
// A new tick is taken only once the last result is loaded into the output register,
// so a stalled result holds off the next tick. Both channels run side by side.
// Reset (rst_n, asynchronous, active low) loads the register defaults and clears
// the time stamp, positions, integrals and last errors.
module dual_angle_pid_servo_control_unit import dapid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dapid_in_if.sink    tick,
    dapid_out_if.source result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_ERR  = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_i_reg;
    logic [GAIN_W-1:0]  gain_d_reg;
    logic [BAND_W-1:0]  dead_band_reg;
    logic [ANGLE_W-1:0] floor_reg;
    logic [ANGLE_W-1:0] ceiling_reg;
    logic               enable_reg;
    logic [1:0]         sensor_ok_reg;

    logic [2:0]          state_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   last_ms_reg;
    logic [TIME_W-1:0]   dt_reg;
    logic [ANGLE_W-1:0]  lang_reg;
    logic [ANGLE_W-1:0]  rang_reg;
    logic [ANGLE_W-1:0]  lt_reg;
    logic [ANGLE_W-1:0]  rt_reg;
    logic [ANGLE_W-1:0]  lpos_reg;
    logic [ANGLE_W-1:0]  rpos_reg;
    logic                ont_reg;
    logic [PULSE_W-1:0]  lp_pend_reg;
    logic [PULSE_W-1:0]  rp_pend_reg;
    logic                out_valid_reg;
    logic [PULSE_W-1:0]  out_lp_reg;
    logic [PULSE_W-1:0]  out_rp_reg;
    logic                out_ont_reg;

    logic [TIME_W-1:0]         dt_next;
    logic signed [ERR_W-1:0]   lerr;
    logic signed [ERR_W-1:0]   rerr;
    logic                      l_in_band;
    logic                      r_in_band;
    chan_cmd_t                 lcmd;
    chan_cmd_t                 rcmd;
    logic                      lbusy;
    logic                      rbusy;
    logic signed [SPEED_W-1:0] lspeed;
    logic signed [SPEED_W-1:0] rspeed;
    logic                      accept;
    logic                      out_load;

    function automatic logic [ANGLE_W-1:0] clamp_target(input logic [ANGLE_W-1:0] t,
                                                        input logic [ANGLE_W-1:0] lo,
                                                        input logic [ANGLE_W-1:0] hi);
        logic [ANGLE_W-1:0] r;
        if (t < lo)
            r = lo;
        else if (t > hi)
            r = hi;
        else
            r = t;
        return r;
    endfunction

    function automatic logic signed [ERR_W-1:0] wrap_err(input logic [ANGLE_W-1:0] t,
                                                         input logic [ANGLE_W-1:0] p);
        logic signed [17:0] e;
        e = signed'({2'b00, t}) - signed'({2'b00, p});
        if (e > 18'sd23040)
            e = e - 18'(ANGLE_FULL);
        if (e < -18'sd23040)
            e = e + 18'(ANGLE_FULL);
        return e[ERR_W-1:0];
    endfunction

    function automatic logic within_band(input logic signed [ERR_W-1:0] e,
                                         input logic [BAND_W-1:0] band);
        logic [ERR_W-1:0] m;
        m = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
        return (m <= {1'b0, band});
    endfunction

    // Configuration port
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= 16'd256;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            dead_band_reg <= 15'd256;
            floor_reg     <= '0;
            ceiling_reg   <= 16'd46079;
            enable_reg    <= 1'b0;
            sensor_ok_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_GAIN_P:    gain_p_reg    <= pwdata[15:0];
                REG_GAIN_I:    gain_i_reg    <= pwdata[15:0];
                REG_GAIN_D:    gain_d_reg    <= pwdata[15:0];
                REG_DEAD_BAND: dead_band_reg <= pwdata[14:0];
                REG_FLOOR:     floor_reg     <= pwdata[15:0];
                REG_CEILING:   ceiling_reg   <= pwdata[15:0];
                REG_ENABLE:    enable_reg    <= pwdata[0];
                REG_SENSOR_OK: sensor_ok_reg <= pwdata[1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_GAIN_P:    prdata = {16'd0, gain_p_reg};
            REG_GAIN_I:    prdata = {16'd0, gain_i_reg};
            REG_GAIN_D:    prdata = {16'd0, gain_d_reg};
            REG_DEAD_BAND: prdata = {17'd0, dead_band_reg};
            REG_FLOOR:     prdata = {16'd0, floor_reg};
            REG_CEILING:   prdata = {16'd0, ceiling_reg};
            REG_ENABLE:    prdata = {31'd0, enable_reg};
            REG_SENSOR_OK: prdata = {30'd0, sensor_ok_reg};
            default:       prdata = '0;
        endcase
    end

    // Handshakes and per-tick arithmetic
    assign tick.ready = (state_reg == S_IDLE);
    assign accept     = tick.valid && tick.ready;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || result.ready);
    assign dt_next    = now_reg - last_ms_reg;
    assign lerr       = wrap_err(lt_reg, lpos_reg);
    assign rerr       = wrap_err(rt_reg, rpos_reg);
    assign l_in_band  = within_band(lerr, dead_band_reg);
    assign r_in_band  = within_band(rerr, dead_band_reg);

    // Channel commands issued once the errors are known
    always_comb
    begin
        lcmd.start = (state_reg == S_ERR) && enable_reg;
        lcmd.run   = !l_in_band;
        lcmd.clear = (state_reg == S_ERR) && !enable_reg;
        rcmd.start = (state_reg == S_ERR) && enable_reg;
        rcmd.run   = !r_in_band;
        rcmd.clear = (state_reg == S_ERR) && !enable_reg;
    end

    dapid_chan u_left
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (lcmd),
        .err    (lerr),
        .dt     (dt_reg),
        .gain_p (gain_p_reg),
        .gain_i (gain_i_reg),
        .gain_d (gain_d_reg),
        .busy   (lbusy),
        .speed  (lspeed)
    );

    dapid_chan u_right
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (rcmd),
        .err    (rerr),
        .dt     (dt_reg),
        .gain_p (gain_p_reg),
        .gain_i (gain_i_reg),
        .gain_d (gain_d_reg),
        .busy   (rbusy),
        .speed  (rspeed)
    );

    // Tick sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            last_ms_reg <= '0;
            lpos_reg    <= '0;
            rpos_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg   <= tick.now_ms;
                        lang_reg  <= tick.left_angle;
                        rang_reg  <= tick.right_angle;
                        lt_reg    <= clamp_target(tick.left_target, floor_reg, ceiling_reg);
                        rt_reg    <= clamp_target(tick.right_target, floor_reg, ceiling_reg);
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (!enable_reg)
                        state_reg <= S_ERR;
                    else if (dt_next < MIN_PERIOD_MS)
                        state_reg <= S_IDLE;
                    else
                    begin
                        last_ms_reg <= now_reg;
                        dt_reg      <= dt_next;
                        if (sensor_ok_reg[0])
                            lpos_reg <= lang_reg;
                        if (sensor_ok_reg[1])
                            rpos_reg <= rang_reg;
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    ont_reg <= l_in_band && r_in_band;
                    if (enable_reg)
                        state_reg <= S_RUN;
                    else
                    begin
                        lp_pend_reg <= PULSE_STOP;
                        rp_pend_reg <= PULSE_STOP;
                        state_reg   <= S_OUT;
                    end
                end
                S_RUN:
                begin
                    if (!lbusy && !rbusy)
                    begin
                        lp_pend_reg <= 11'({1'b0, PULSE_STOP} + {{2{lspeed[9]}}, lspeed});
                        rp_pend_reg <= 11'({1'b0, PULSE_STOP} + {{2{rspeed[9]}}, rspeed});
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_lp_reg  <= lp_pend_reg;
            out_rp_reg  <= rp_pend_reg;
            out_ont_reg <= ont_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.left_pulse  = out_lp_reg;
    assign result.right_pulse = out_rp_reg;
    assign result.on_target   = out_ont_reg;

endmodule

[hdl/dapid_chan.sv]
module dapid_chan import dapid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  chan_cmd_t                 cmd,
    input  logic signed [ERR_W-1:0]   err,
    input  logic [TIME_W-1:0]         dt,
    input  logic [GAIN_W-1:0]         gain_p,
    input  logic [GAIN_W-1:0]         gain_i,
    input  logic [GAIN_W-1:0]         gain_d,
    output logic                      busy,
    output logic signed [SPEED_W-1:0] speed
);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_MUL  = 3'd1;
    localparam logic [2:0] P_DIV  = 3'd2;
    localparam logic [2:0] P_ACC  = 3'd3;
    localparam logic [2:0] P_MAC  = 3'd4;
    localparam logic [2:0] P_FIN  = 3'd5;

    logic [2:0]                phase_reg;
    logic [5:0]                cnt_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   last_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [TIME_W-1:0]         dts_reg;
    logic [52:0]               prod_reg;
    logic [6:0]                rem_reg;
    logic [25:0]               dnum_reg;
    logic [TIME_W-1:0]         drem_reg;
    logic                      dneg_reg;
    logic [GAIN_W-1:0]         gp_reg;
    logic [GAIN_W-1:0]         gi_reg;
    logic [GAIN_W-1:0]         gd_reg;
    logic signed [39:0]        hi_reg;
    logic [15:0]               lo_reg;
    logic signed [SPEED_W-1:0] speed_reg;

    logic [15:0]         emag;
    logic [16:0]         mul_sum;
    logic [47:0]         mul_next;
    logic [7:0]          div_t;
    logic                div_ge;
    logic [6:0]          div_r;
    logic [32:0]         dd_t;
    logic                dd_ge;
    logic [31:0]         dd_r;
    logic signed [16:0]  diff;
    logic [16:0]         dmag;
    logic [25:0]         dnum_init;
    logic                q_big;
    logic [26:0]         qc;
    logic signed [26:0]  qs;
    logic signed [26:0]  a_sum;
    logic signed [ACC_W-1:0] acc_new;
    logic signed [24:0]  e25;
    logic signed [26:0]  d27;
    logic signed [35:0]  d36;
    logic signed [39:0]  add_e;
    logic signed [39:0]  add_a;
    logic signed [39:0]  add_d;
    logic signed [39:0]  mac_s;
    logic signed [31:0]  q_floor;
    logic signed [31:0]  q_trunc;
    logic signed [SPEED_W-1:0] speed_next;

    // Shift-add step of |err| * dt, one bit of dt per cycle
    assign emag     = err_reg[15] ? 16'(-err_reg) : 16'(err_reg);
    assign mul_sum  = {1'b0, prod_reg[47:32]} + (dts_reg[0] ? {1'b0, emag} : 17'd0);
    assign mul_next = {mul_sum, prod_reg[31:1]};

    // Restoring division by 125, one quotient bit per cycle
    assign div_t  = {rem_reg, prod_reg[52]};
    assign div_ge = (div_t >= 8'd125);
    assign div_r  = div_ge ? 7'(div_t - 8'd125) : div_t[6:0];

    // Restoring division of the scaled error change by dt
    assign dd_t  = {drem_reg, dnum_reg[25]};
    assign dd_ge = (dd_t >= {1'b0, dt});
    assign dd_r  = dd_ge ? 32'(dd_t - {1'b0, dt}) : dd_t[31:0];

    // Error change against the last error that ran the loop
    assign diff      = 17'(signed'({err[15], err}) - signed'({last_reg[15], last_reg}));
    assign dmag      = diff[16] ? 17'(-diff) : 17'(diff);
    assign dnum_init = 26'({9'd0, dmag} * 26'd1000);

    // Integral update with saturation
    assign q_big   = |prod_reg[52:24];
    assign qc      = q_big ? 27'h1000000 : {3'd0, prod_reg[23:0]};
    assign qs      = err_reg[15] ? 27'(-signed'(qc)) : signed'(qc);
    assign a_sum   = 27'({{3{acc_reg[23]}}, acc_reg}) + qs;
    always_comb
    begin
        priority if (a_sum > 27'sd6553600)
            acc_new = 24'(ACC_LIMIT);
        else if (a_sum < -27'sd6553600)
            acc_new = 24'(-ACC_LIMIT);
        else
            acc_new = a_sum[23:0];
    end

    // Combined shift-add of the three gains, one gain bit per cycle
    assign e25   = {err_reg, 9'd0};
    assign d27   = dneg_reg ? 27'(-signed'({1'b0, dnum_reg})) : signed'({1'b0, dnum_reg});
    assign d36   = {d27, 9'd0};
    assign add_e = gp_reg[0] ? {{15{e25[24]}}, e25} : 40'sd0;
    assign add_a = gi_reg[0] ? {{16{acc_reg[23]}}, acc_reg} : 40'sd0;
    assign add_d = gd_reg[0] ? {{4{d36[35]}}, d36} : 40'sd0;
    assign mac_s = hi_reg + add_e + add_a + add_d;

    // Divide by 2^24 toward zero and limit the speed
    assign q_floor = hi_reg[39:8];
    assign q_trunc = q_floor + ((hi_reg[39] && ((|hi_reg[7:0]) || (|lo_reg))) ? 32'sd1 : 32'sd0);
    always_comb
    begin
        priority if (q_trunc > 32'(SPEED_LIMIT))
            speed_next = 10'(SPEED_LIMIT);
        else if (q_trunc < 32'(-SPEED_LIMIT))
            speed_next = 10'(-SPEED_LIMIT);
        else
            speed_next = q_trunc[9:0];
    end

    // Sequencer of one PID step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            last_reg  <= '0;
            speed_reg <= '0;
        end
        else
        begin
            unique case (phase_reg)
                P_IDLE:
                begin
                    if (cmd.clear)
                        acc_reg <= '0;
                    if (cmd.start)
                    begin
                        if (cmd.run)
                        begin
                            err_reg   <= err;
                            last_reg  <= err;
                            dts_reg   <= dt;
                            prod_reg  <= '0;
                            dnum_reg  <= dnum_init;
                            drem_reg  <= '0;
                            dneg_reg  <= diff[16];
                            cnt_reg   <= '0;
                            phase_reg <= P_MUL;
                        end
                        else
                        begin
                            acc_reg   <= '0;
                            speed_reg <= '0;
                        end
                    end
                end
                P_MUL:
                begin
                    dts_reg <= dts_reg >> 1;
                    if (cnt_reg < 6'd26)
                    begin
                        drem_reg <= dd_r;
                        dnum_reg <= {dnum_reg[24:0], dd_ge};
                    end
                    if (cnt_reg == 6'd31)
                    begin
                        prod_reg  <= {mul_next[46:0], 6'd0};
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        phase_reg <= P_DIV;
                    end
                    else
                    begin
                        prod_reg[47:0] <= mul_next;
                        cnt_reg        <= cnt_reg + 6'd1;
                    end
                end
                P_DIV:
                begin
                    prod_reg <= {prod_reg[51:0], div_ge};
                    rem_reg  <= div_r;
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd52)
                        phase_reg <= P_ACC;
                end
                P_ACC:
                begin
                    acc_reg   <= acc_new;
                    gp_reg    <= gain_p;
                    gi_reg    <= gain_i;
                    gd_reg    <= gain_d;
                    hi_reg    <= '0;
                    lo_reg    <= '0;
                    cnt_reg   <= '0;
                    phase_reg <= P_MAC;
                end
                P_MAC:
                begin
                    hi_reg  <= {mac_s[39], mac_s[39:1]};
                    lo_reg  <= {mac_s[0], lo_reg[15:1]};
                    gp_reg  <= gp_reg >> 1;
                    gi_reg  <= gi_reg >> 1;
                    gd_reg  <= gd_reg >> 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd15)
                        phase_reg <= P_FIN;
                end
                P_FIN:
                begin
                    speed_reg <= speed_next;
                    phase_reg <= P_IDLE;
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign busy  = (phase_reg != P_IDLE);
    assign speed = speed_reg;

endmodule
